@@ rtl/nfsa_pkg.sv @@
// Shared constants, codes and types for the next-fit slot allocator.
package nfsa_pkg;

  localparam int SLOTS       = 1024;
  localparam int GROUP_BITS  = 16;
  localparam int SLOT_BITS   = $clog2(SLOTS);
  localparam int COL_BITS    = 5;
  localparam int COLS        = 1 << COL_BITS;
  localparam int ROWS        = SLOTS / COLS;
  localparam int ROW_BITS    = SLOT_BITS - COL_BITS;
  localparam int COUNT_BITS  = SLOT_BITS + 1;
  localparam int CMD_BITS    = 2;
  localparam int STATUS_BITS = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ALLOC      = 2'd0,
    CMD_FREE       = 2'd1,
    CMD_GROUP_FREE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_ALLOC = 2'd2
  } status_t;

  typedef struct packed {
    logic                en;
    logic [ROW_BITS-1:0] row;
    logic [COLS-1:0]     word;
  } vwr_t;

endpackage

@@ rtl/nfsa_ram.sv @@
// Generic one-write, one-read synchronous RAM with registered read data.
module nfsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/nfsa_valid_store.sv @@
// Slot valid bits stored as rows of a word-wide RAM, with per-row valid flags.
module nfsa_valid_store import nfsa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [ROW_BITS-1:0] rd_row,
  output logic [COLS-1:0]     rd_word,
  input  vwr_t                wr
);

  logic [ROWS-1:0] row_valid;
  logic            rd_valid;
  logic [COLS-1:0] ram_q;

  nfsa_ram #(
    .WIDTH (COLS),
    .DEPTH (ROWS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.row),
    .wr_data (wr.word),
    .rd_en   (rd_en),
    .rd_addr (rd_row),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (wr.en) begin
        row_valid[wr.row] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= row_valid[rd_row];
      end
    end
  end

  assign rd_word = rd_valid ? ram_q : '0;

endmodule

@@ rtl/next_fit_slot_allocator_groups.sv @@
// Next-fit slot allocator with group tags: command sequencer and tag memory.
// Allocate: done when a free slot is found; 32-slot rows are examined in turn (1 to 33 rows).
// Free: done after its row is read. Group free: done after SLOTS tags (one tag read per cycle).
// Table full and the unused code: done in the cycle after acceptance. One request at a time.
// A new request is taken in the cycle that done is high; results are never stalled.
// Reset clears the row flags of the valid store at once: no clearing pass.
module next_fit_slot_allocator_groups import nfsa_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [CMD_BITS-1:0]    command,
  input  logic [SLOT_BITS-1:0]   slot,
  input  logic [GROUP_BITS-1:0]  group_tag,
  output logic                   busy,
  output logic                   done,
  output logic [SLOT_BITS-1:0]   handle,
  output logic [STATUS_BITS-1:0] status,
  output logic [COUNT_BITS-1:0]  freed,
  output logic [COUNT_BITS-1:0]  live
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_FREE,
    S_SWEEP
  } state_t;

  state_t                 state;
  cmd_t                   cmd_r;
  logic [SLOT_BITS-1:0]   slot_r;
  logic [GROUP_BITS-1:0]  tag_r;
  logic [ROW_BITS-1:0]    row_r;
  logic                   first_r;
  logic [SLOT_BITS-1:0]   scan_ptr;
  logic [COUNT_BITS-1:0]  live_count;
  logic [SLOT_BITS-1:0]   gaddr;
  logic                   issue_on;
  logic                   p_vld;
  logic [SLOT_BITS-1:0]   p_addr;
  logic [COLS-1:0]        work;
  logic [COUNT_BITS-1:0]  freed_cnt;

  logic                   accept;
  logic                   vs_rd_en;
  logic [ROW_BITS-1:0]    vs_rd_row;
  logic [COLS-1:0]        vs_word;
  vwr_t                   vs_wr;
  logic                   tag_wr_en;
  logic [GROUP_BITS-1:0]  tag_rd_data;

  logic [COLS-1:0]        low_mask;
  logic [COLS-1:0]        search;
  logic                   hit;
  logic [COL_BITS-1:0]    found_col;
  logic [SLOT_BITS-1:0]   new_slot;
  logic                   fbit;
  logic [COL_BITS-1:0]    p_col;
  logic [COLS-1:0]        word_cur;
  logic                   match;
  logic [COLS-1:0]        word_new;
  logic [COUNT_BITS-1:0]  freed_total;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign live   = live_count;

  // next-fit search within the current row
  assign low_mask = (COLS'(1) << scan_ptr[COL_BITS-1:0]) - COLS'(1);
  assign search   = vs_word | (first_r ? low_mask : '0);
  assign hit      = ~&search;

  always_comb begin
    found_col = '0;
    for (int i = COLS - 1; i >= 0; i--) begin
      if (!search[i]) begin
        found_col = COL_BITS'(i);
      end
    end
  end

  assign new_slot = {row_r, found_col};
  assign fbit     = vs_word[slot_r[COL_BITS-1:0]];

  // group sweep evaluation stage
  assign p_col       = p_addr[COL_BITS-1:0];
  assign word_cur    = (p_col == '0) ? vs_word : work;
  assign match       = word_cur[p_col] && (tag_rd_data == tag_r);
  assign word_new    = word_cur & ~({{(COLS-1){1'b0}}, match} << p_col);
  assign freed_total = freed_cnt + {{(COUNT_BITS-1){1'b0}}, match};

  always_comb begin
    vs_rd_en  = 1'b0;
    vs_rd_row = row_r + 1'b1;
    case (state)
      S_IDLE: begin
        vs_rd_en  = accept;
        vs_rd_row = (command == CMD_FREE) ? slot[SLOT_BITS-1:COL_BITS]
                                          : scan_ptr[SLOT_BITS-1:COL_BITS];
      end
      S_ALLOC: begin
        vs_rd_en = !hit;
      end
      S_SWEEP: begin
        vs_rd_en  = issue_on;
        vs_rd_row = gaddr[SLOT_BITS-1:COL_BITS];
      end
      default: ;
    endcase
  end

  always_comb begin
    vs_wr.en   = 1'b0;
    vs_wr.row  = row_r;
    vs_wr.word = vs_word | (COLS'(1) << found_col);
    case (state)
      S_ALLOC: begin
        vs_wr.en = hit;
      end
      S_FREE: begin
        vs_wr.en   = fbit;
        vs_wr.row  = slot_r[SLOT_BITS-1:COL_BITS];
        vs_wr.word = vs_word & ~(COLS'(1) << slot_r[COL_BITS-1:0]);
      end
      S_SWEEP: begin
        vs_wr.en   = p_vld && (p_col == COL_BITS'(COLS - 1));
        vs_wr.row  = p_addr[SLOT_BITS-1:COL_BITS];
        vs_wr.word = word_new;
      end
      default: ;
    endcase
  end

  assign tag_wr_en = (state == S_ALLOC) && hit;

  nfsa_valid_store u_valid (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (vs_rd_en),
    .rd_row  (vs_rd_row),
    .rd_word (vs_word),
    .wr      (vs_wr)
  );

  nfsa_ram #(
    .WIDTH (GROUP_BITS),
    .DEPTH (SLOTS)
  ) u_tags (
    .clk     (clk),
    .wr_en   (tag_wr_en),
    .wr_addr (new_slot),
    .wr_data (tag_r),
    .rd_en   ((state == S_SWEEP) && issue_on),
    .rd_addr (gaddr),
    .rd_data (tag_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      scan_ptr   <= '0;
      live_count <= '0;
      issue_on   <= 1'b0;
      p_vld      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_r     <= cmd_t'(command);
            slot_r    <= slot;
            tag_r     <= group_tag;
            row_r     <= scan_ptr[SLOT_BITS-1:COL_BITS];
            first_r   <= 1'b1;
            gaddr     <= '0;
            issue_on  <= 1'b1;
            p_vld     <= 1'b0;
            freed_cnt <= '0;
            handle    <= '0;
            freed     <= '0;
            status    <= ST_OK;
            case (command)
              CMD_ALLOC: begin
                if (live_count == COUNT_BITS'(SLOTS)) begin
                  done   <= 1'b1;
                  status <= ST_FULL;
                end else begin
                  state <= S_ALLOC;
                end
              end
              CMD_FREE: begin
                state <= S_FREE;
              end
              CMD_GROUP_FREE: begin
                state <= S_SWEEP;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_ALLOC: begin
          if (hit) begin
            scan_ptr   <= new_slot;
            live_count <= live_count + 1'b1;
            handle     <= new_slot;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else begin
            row_r   <= row_r + 1'b1;
            first_r <= 1'b0;
          end
        end
        S_FREE: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (fbit) begin
            live_count <= live_count - 1'b1;
            freed      <= COUNT_BITS'(1);
          end else begin
            status <= ST_NOT_ALLOC;
          end
        end
        S_SWEEP: begin
          if (issue_on) begin
            gaddr  <= gaddr + 1'b1;
            p_addr <= gaddr;
            p_vld  <= 1'b1;
            if (gaddr == SLOT_BITS'(SLOTS - 1)) begin
              issue_on <= 1'b0;
            end
          end else begin
            p_vld <= 1'b0;
          end
          if (p_vld) begin
            work      <= word_new;
            freed_cnt <= freed_total;
            if (p_addr == SLOT_BITS'(SLOTS - 1)) begin
              live_count <= live_count - freed_total;
              freed      <= freed_total;
              done       <= 1'b1;
              state      <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live_count <= COUNT_BITS'(SLOTS))
    else $error("live count above table size");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> live_count == COUNT_BITS'(SLOTS))
    else $error("full status while slots remain");

  a_alloc_ptr: assert property (@(posedge clk) disable iff (rst)
    (done && cmd_r == CMD_ALLOC && status == ST_OK) |-> handle == scan_ptr)
    else $error("scan pointer not left on granted slot");

  a_sweep_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_GROUP_FREE) |=> busy)
    else $error("group free request not started");

  a_sweep_no_tag_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> !tag_wr_en)
    else $error("tag write during group sweep");

endmodule

@@ verif/nfsa_checker.sv @@
// Checker for the next-fit slot allocator: predicts each request's outcome and compares it.
`timescale 1ns / 1ps
module nfsa_checker import nfsa_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   busy,
  input  logic [CMD_BITS-1:0]    command,
  input  logic [SLOT_BITS-1:0]   slot,
  input  logic [GROUP_BITS-1:0]  group_tag,
  input  logic                   done,
  input  logic [SLOT_BITS-1:0]   handle,
  input  logic [STATUS_BITS-1:0] status,
  input  logic [COUNT_BITS-1:0]  freed,
  input  logic [COUNT_BITS-1:0]  live,
  output int                     mismatches,
  output int                     outstanding
);

  typedef struct {
    logic [SLOT_BITS-1:0]  handle;
    status_t               status;
    logic [COUNT_BITS-1:0] freed;
    logic [COUNT_BITS-1:0] live;
  } outcome_t;

  bit                    slot_taken [SLOTS];
  logic [GROUP_BITS-1:0] slot_tag   [SLOTS];
  logic [SLOT_BITS-1:0]  next_slot;
  logic [COUNT_BITS-1:0] live_slots;
  outcome_t              awaited_outcomes [$];

  task automatic report_mismatch(input string what);
    if (mismatches < 100) $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  function automatic outcome_t apply_request(input logic [CMD_BITS-1:0]   cmd,
                                             input logic [SLOT_BITS-1:0]  target,
                                             input logic [GROUP_BITS-1:0] tag);
    outcome_t o;
    o.handle = '0;
    o.status = ST_OK;
    o.freed  = '0;
    case (cmd)
      CMD_ALLOC: begin
        if (live_slots >= SLOTS) begin
          o.status = ST_FULL;
        end else begin
          // scan wraps naturally at the slot width
          while (slot_taken[next_slot]) next_slot = next_slot + 1'b1;
          slot_taken[next_slot] = 1'b1;
          slot_tag[next_slot]   = tag;
          live_slots            = live_slots + 1'b1;
          o.handle              = next_slot;
        end
      end
      CMD_FREE: begin
        if (int'(target) < SLOTS && slot_taken[target]) begin
          slot_taken[target] = 1'b0;
          live_slots         = live_slots - 1'b1;
          o.freed            = COUNT_BITS'(1);
        end else begin
          o.status = ST_NOT_ALLOC;
        end
      end
      CMD_GROUP_FREE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_taken[i] && slot_tag[i] == tag) begin
            slot_taken[i] = 1'b0;
            live_slots    = live_slots - 1'b1;
            o.freed       = o.freed + 1'b1;
          end
        end
      end
      default: ;
    endcase
    o.live = live_slots;
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      foreach (slot_taken[i]) slot_taken[i] = 1'b0;
      next_slot  = '0;
      live_slots = '0;
      awaited_outcomes.delete();
    end else begin
      // retire before accepting: a new request may be taken on the done cycle
      if (done === 1'b1) begin
        if (awaited_outcomes.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          want = awaited_outcomes.pop_front();
          check_field("handle", 32'(handle), 32'(want.handle));
          check_field("status", 32'(status), 32'(want.status));
          check_field("freed", 32'(freed), 32'(want.freed));
          check_field("live", 32'(live), 32'(want.live));
        end
      end
      if (start && busy === 1'b0)
        awaited_outcomes.push_back(apply_request(command, slot, group_tag));
    end
    outstanding <= awaited_outcomes.size();
  end

endmodule

@@ verif/tb.sv @@
// Top-level testbench for the next-fit slot allocator: request stimulus and verdict.
`timescale 1ns / 1ps
module tb;
  import nfsa_pkg::*;

  localparam logic [CMD_BITS-1:0]   CMD_UNUSED = 2'd3;
  localparam logic [GROUP_BITS-1:0] TAG_POOL [4] = '{16'h0000, 16'hFFFF, 16'h8001, 16'h7FFE};

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   start     = 1'b0;
  logic [CMD_BITS-1:0]    command   = '0;
  logic [SLOT_BITS-1:0]   slot      = '0;
  logic [GROUP_BITS-1:0]  group_tag = '0;
  logic                   busy;
  logic                   done;
  logic [SLOT_BITS-1:0]   handle;
  logic [STATUS_BITS-1:0] status;
  logic [COUNT_BITS-1:0]  freed;
  logic [COUNT_BITS-1:0]  live;
  int                     mismatches;
  int                     outstanding;
  int                     zero_run = 0;
  int                     sent [4] = '{0, 0, 0, 0};

  next_fit_slot_allocator_groups DUT (
    .clk, .rst, .start, .command, .slot, .group_tag,
    .busy, .done, .handle, .status, .freed, .live
  );

  nfsa_checker u_checker (
    .clk, .rst, .start, .busy, .command, .slot, .group_tag,
    .done, .handle, .status, .freed, .live,
    .mismatches, .outstanding
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [GROUP_BITS-1:0] pick_tag();
    if ($urandom_range(0, 9) < 6) return TAG_POOL[$urandom_range(0, 3)];
    return GROUP_BITS'($urandom_range(0, 65535));
  endfunction

  function automatic logic [SLOT_BITS-1:0] pick_slot();
    if ($urandom_range(0, 1) == 0) return SLOT_BITS'($urandom_range(0, 127));
    return SLOT_BITS'($urandom_range(0, SLOTS - 1));
  endfunction

  // hold start until the request is taken; leave start high for back-to-back requests
  task automatic issue(input logic [CMD_BITS-1:0]   cmd,
                       input logic [SLOT_BITS-1:0]  target,
                       input logic [GROUP_BITS-1:0] tag);
    int gap;
    if (zero_run > 0) begin
      zero_run--;
      gap = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      zero_run = $urandom_range(10, 30);
      gap      = 0;
    end else begin
      gap = $urandom_range(0, 10);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    command   <= cmd;
    slot      <= target;
    group_tag <= tag;
    sent[cmd]++;
    do @(posedge clk); while (busy);
  endtask

  task automatic random_request(input int w_alloc, input int w_free, input int w_group);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < w_alloc)
      issue(CMD_ALLOC, SLOT_BITS'($urandom_range(0, SLOTS - 1)), pick_tag());
    else if (pick < w_alloc + w_free)
      issue(CMD_FREE, pick_slot(), GROUP_BITS'($urandom_range(0, 65535)));
    else if (pick < w_alloc + w_free + w_group)
      issue(CMD_GROUP_FREE, SLOT_BITS'($urandom_range(0, SLOTS - 1)), pick_tag());
    else
      issue(CMD_UNUSED, SLOT_BITS'($urandom_range(0, SLOTS - 1)),
            GROUP_BITS'($urandom_range(0, 65535)));
  endtask

  // drop start and hold until every request has its result
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    issue(CMD_ALLOC, 10'd0, 16'hFFFF);
    issue(CMD_ALLOC, 10'd1023, 16'h0000);
    issue(CMD_ALLOC, 10'd0, 16'h8001);
    issue(CMD_ALLOC, 10'd0, 16'h7FFE);
    issue(CMD_FREE, 10'd0, 16'h0000);
    issue(CMD_FREE, 10'd0, 16'hFFFF);
    issue(CMD_FREE, 10'd1023, 16'h0000);
    issue(CMD_UNUSED, 10'd1023, 16'hFFFF);
    issue(CMD_GROUP_FREE, 10'd0, 16'h1234);
    issue(CMD_GROUP_FREE, 10'd1023, 16'h0000);
    issue(CMD_ALLOC, 10'd0, 16'hAAAA);
    issue(CMD_ALLOC, 10'd0, 16'h5555);
    issue(CMD_FREE, 10'd3, 16'h0000);
    issue(CMD_ALLOC, 10'd0, 16'hFFFF);
    issue(CMD_GROUP_FREE, 10'd0, 16'hFFFF);
    issue(CMD_UNUSED, 10'd0, 16'h0000);
    wait_idle();

    repeat (250) random_request(55, 25, 10);
    wait_idle();

    // long allocation burst to load the table
    repeat (380) issue(CMD_ALLOC, SLOT_BITS'($urandom_range(0, SLOTS - 1)), pick_tag());
    wait_idle();

    repeat (200) random_request(30, 45, 15);
    foreach (TAG_POOL[i]) begin
      issue(CMD_GROUP_FREE, SLOT_BITS'($urandom_range(0, SLOTS - 1)), TAG_POOL[i]);
    end
    wait_idle();
    repeat (40) @(posedge clk);

    $display("Sent %0d allocate, %0d free, %0d group free and %0d unused-code requests",
             sent[CMD_ALLOC], sent[CMD_FREE], sent[CMD_GROUP_FREE], sent[CMD_UNUSED]);
    $display("Table was loaded by an allocation burst, then drained by single and group frees");
    if (mismatches == 0) begin
      $display("next_fit_slot_allocator_groups test passed");
    end else begin
      $display("next_fit_slot_allocator_groups test failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Timeout with %0d results outstanding", outstanding);
    $display("next_fit_slot_allocator_groups test failed");
    $finish;
  end

endmodule
